FILE: rtl/vsbc_pkg.sv
package vsbc_pkg;

	localparam int VALUE_BITS = 64;
	localparam int GROUP_BITS = 7;
	localparam int GROUPS     = (VALUE_BITS + GROUP_BITS - 1) / GROUP_BITS;
	localparam int PAD_BITS   = GROUPS * GROUP_BITS;
	localparam int CNT_W      = $clog2(GROUPS + 1);

	localparam logic ACT_ENCODE  = 1'b0;
	localparam logic ACT_DECODE  = 1'b1;
	localparam logic KIND_BYTE   = 1'b0;
	localparam logic KIND_NUMBER = 1'b1;

	typedef struct packed {
		logic       busy;
		logic       emit;
		logic [7:0] code;
		logic       fin;
	} enc_stat_t;

endpackage

FILE: rtl/vsbc_enc.sv
module vsbc_enc import vsbc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] value,
	input  logic        advance,
	output enc_stat_t   stat
);

	logic [PAD_BITS-1:0]   sr_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  busy_q;
	logic                  skip_q;
	logic [GROUP_BITS-1:0] top;
	logic                  final_grp;
	logic                  skipping;

	assign top       = sr_q[PAD_BITS-1 -: GROUP_BITS];
	assign final_grp = (cnt_q == CNT_W'(1));
	// leading zero groups are shifted out without a word
	assign skipping  = skip_q && (top == '0) && !final_grp;

	assign stat.busy = busy_q;
	assign stat.emit = busy_q && !skipping;
	assign stat.code = {final_grp, top};
	assign stat.fin  = final_grp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			skip_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			skip_q <= 1'b1;
			cnt_q  <= CNT_W'(GROUPS);
		end else if (busy_q) begin
			if (skipping) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end else if (advance) begin
				cnt_q  <= cnt_q - CNT_W'(1);
				skip_q <= 1'b0;
				if (final_grp) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sr_q <= PAD_BITS'(value[VALUE_BITS-1:0]);
		end else if (busy_q && (skipping || advance)) begin
			sr_q <= {sr_q[PAD_BITS-GROUP_BITS-1:0], {GROUP_BITS{1'b0}}};
		end
	end

endmodule

FILE: rtl/vsbc_dec.sv
module vsbc_dec import vsbc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic [7:0]            byte_in,
	output logic                  done,
	output logic [VALUE_BITS-1:0] number,
	output logic                  lost
);

	logic [VALUE_BITS-1:0] acc_q;
	logic                  lost_q;

	assign lost   = lost_q || (acc_q[VALUE_BITS-1 -: GROUP_BITS] != '0);
	assign number = {acc_q[VALUE_BITS-GROUP_BITS-1:0], byte_in[GROUP_BITS-1:0]};
	assign done   = step && byte_in[7];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			lost_q <= 1'b0;
		end else if (step) begin
			if (byte_in[7]) begin
				acc_q  <= '0;
				lost_q <= 1'b0;
			end else begin
				acc_q  <= number;
				lost_q <= lost;
			end
		end
	end

endmodule

FILE: rtl/varint_seven_bit_codec.sv
// channel   direction  handshake                   payload
// item      in         item_valid / item_stall     action, value_in, byte_in
// result    out        result_valid / result_stall kind, byte_out, value_out, last, overflow
//
// a decode word with bit 7 set leaves a number result
// an encode word loads a 70-bit digit shift register, then shifts out one 7-bit group
// per cycle; leading zero groups go without a word, other groups only when not stalled
// the encoder shift register sets the encode rate; a stalled result holds it
// arst_n clears the accumulator, the overflow flag and all valid state
module varint_seven_bit_codec import vsbc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic        action,
	input  logic [63:0] value_in,
	input  logic [7:0]  byte_in,
	output logic        result_valid,
	input  logic        result_stall,
	output logic        kind,
	output logic [7:0]  byte_out,
	output logic [63:0] value_out,
	output logic        last,
	output logic        overflow
);

	enc_stat_t             enc_st;
	logic                  slot_free;
	logic                  item_acc;
	logic                  dec_done;
	logic [VALUE_BITS-1:0] dec_number;
	logic                  dec_lost;
	logic                  out_valid_q;
	logic                  kind_q;
	logic [7:0]            byte_q;
	logic [63:0]           value_q;
	logic                  last_q;
	logic                  ovf_q;

	assign slot_free  = !out_valid_q || !result_stall;
	assign item_stall = enc_st.busy || !slot_free;
	assign item_acc   = item_valid && !item_stall;

	vsbc_enc u_enc (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (item_acc && (action == ACT_ENCODE)),
		.value   (value_in),
		.advance (slot_free),
		.stat    (enc_st)
	);

	vsbc_dec u_dec (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (item_acc && (action == ACT_DECODE)),
		.byte_in (byte_in),
		.done    (dec_done),
		.number  (dec_number),
		.lost    (dec_lost)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (slot_free) begin
			out_valid_q <= enc_st.emit || dec_done;
		end
	end

	always_ff @(posedge clk) begin
		if (slot_free && enc_st.emit) begin
			kind_q  <= KIND_BYTE;
			byte_q  <= enc_st.code;
			value_q <= '0;
			last_q  <= enc_st.fin;
			ovf_q   <= 1'b0;
		end else if (dec_done) begin
			kind_q  <= KIND_NUMBER;
			byte_q  <= '0;
			value_q <= 64'(dec_number);
			last_q  <= 1'b1;
			ovf_q   <= dec_lost;
		end
	end

	assign result_valid = out_valid_q;
	assign kind         = kind_q;
	assign byte_out     = byte_q;
	assign value_out    = value_q;
	assign last         = last_q;
	assign overflow     = ovf_q;

	a_stop_bit: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (kind == KIND_BYTE) |-> (last == byte_out[7]))
		else $error("stop bit and last disagree");

	a_number_whole: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (kind == KIND_NUMBER) |-> last && (byte_out == 8'd0))
		else $error("number result malformed");

	a_enc_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		enc_st.busy |-> item_stall)
		else $error("item taken while encoding");

	a_enc_starts: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && (action == ACT_ENCODE) |=> enc_st.busy)
		else $error("encoder did not start");

endmodule

FILE: tb/tb_varint_seven_bit_codec.sv
`timescale 1ns / 100ps

module tb_varint_seven_bit_codec;
	import vsbc_pkg::*;

	localparam int          CYCLE_LIMIT = 200000;
	localparam int          HOLD_CYCLES = 100;
	localparam logic [7:0]  STOP_BIT    = 8'h80;

	typedef struct packed {
		logic        kind;
		logic [7:0]  byte_out;
		logic [63:0] value_out;
		logic        last;
		logic        overflow;
	} codec_result_t;

	class varint_tracker;
		logic [VALUE_BITS-1:0] acc;
		logic                  acc_lost;
		codec_result_t         results_due[$];
		int                    errors;

		function new();
			acc = '0;
			acc_lost = 1'b0;
			errors = 0;
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		function void note_word(logic act, logic [63:0] value, logic [7:0] code);
			logic [VALUE_BITS-1:0] v;
			logic [VALUE_BITS-1:0] nxt;
			logic [6:0]            grp[GROUPS];
			int                    n;
			int                    k;
			v = value[VALUE_BITS-1:0];
			if (act == ACT_ENCODE) begin
				n = 0;
				while (v != 0) begin
					grp[n] = v[6:0];
					v = v >> GROUP_BITS;
					n++;
				end
				if (n == 0)
					results_due.push_back('{KIND_BYTE, STOP_BIT, 64'd0, 1'b1, 1'b0});
				for (k = n - 1; k >= 0; k--)
					results_due.push_back('{KIND_BYTE, {k == 0, grp[k]}, 64'd0, k == 0, 1'b0});
			end else begin
				if ((acc >> (VALUE_BITS - GROUP_BITS)) != 0)
					acc_lost = 1'b1;
				nxt = (acc << GROUP_BITS) + code[6:0];
				if (!code[7]) begin
					acc = nxt;
				end else begin
					results_due.push_back('{KIND_NUMBER, 8'd0, 64'(nxt), 1'b1, acc_lost});
					acc = '0;
					acc_lost = 1'b0;
				end
			end
		endfunction

		task check_word(codec_result_t got);
			codec_result_t want;
			if (results_due.size() == 0) begin
				report($sformatf("unexpected word kind=%0b byte=%02h value=%016h last=%0b ovf=%0b",
					got.kind, got.byte_out, got.value_out, got.last, got.overflow));
			end else begin
				want = results_due.pop_front();
				if (got !== want)
					report($sformatf("kind %0b/%0b byte %02h/%02h value %016h/%016h last %0b/%0b ovf %0b/%0b",
						got.kind, want.kind, got.byte_out, want.byte_out,
						got.value_out, want.value_out, got.last, want.last,
						got.overflow, want.overflow));
			end
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_stall;
	logic        action = ACT_ENCODE;
	logic [63:0] value_in = 64'd0;
	logic [7:0]  byte_in = 8'd0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic        kind;
	logic [7:0]  byte_out;
	logic [63:0] value_out;
	logic        last;
	logic        overflow;

	varint_tracker codec_track = new();
	int            words_sent = 0;
	int            cycle_count = 0;
	bit            send_burst = 1'b0;
	bit            take_burst = 1'b0;
	bit            hold_pending = 1'b0;

	varint_seven_bit_codec dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.action       (action),
		.value_in     (value_in),
		.byte_in      (byte_in),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.kind         (kind),
		.byte_out     (byte_out),
		.value_out    (value_out),
		.last         (last),
		.overflow     (overflow)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			codec_track.check_word('{kind, byte_out, value_out, last, overflow});
	end

	initial begin : result_sink
		int gap;
		forever begin
			if (hold_pending) begin
				hold_pending = 1'b0;
				gap = HOLD_CYCLES;
			end else begin
				gap = take_burst ? 0 : $urandom_range(0, 8);
			end
			if (gap > 0) begin
				result_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			result_stall <= 1'b0;
			do @(posedge clk); while (!result_valid);
		end
	end

	function automatic logic [63:0] rand_value();
		return {$urandom, $urandom} >> $urandom_range(0, 63);
	endfunction

	task automatic send_word(logic act, logic [63:0] value, logic [7:0] code);
		int gap;
		gap = send_burst ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		action <= act;
		value_in <= value;
		byte_in <= code;
		do @(posedge clk); while (item_stall);
		codec_track.note_word(act, value, code);
		words_sent++;
	endtask

	task automatic enc(logic [63:0] value);
		send_word(ACT_ENCODE, value, 8'($urandom));
	endtask

	task automatic dec(logic [7:0] code);
		send_word(ACT_DECODE, {$urandom, $urandom}, code);
	endtask

	// feeds the groups of a number msb first, optionally with an encode in between
	task automatic send_number(logic [63:0] v, bit mixed);
		logic [69:0] wide;
		int          n;
		int          k;
		int          cut;
		wide = {6'd0, v};
		n = 1;
		while (n < GROUPS && (wide >> (GROUP_BITS * n)) != 0)
			n++;
		repeat ($urandom_range(0, 2)) dec(8'h00);
		cut = mixed ? $urandom_range(0, n - 1) : -1;
		for (k = n - 1; k >= 0; k--) begin
			if (k == cut)
				enc(rand_value());
			dec({k == 0, wide[GROUP_BITS * k +: GROUP_BITS]});
		end
	endtask

	initial begin : stimulus
		bit pressed;
		int pick;
		pressed = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		enc(64'd0);
		enc(64'hFFFF_FFFF_FFFF_FFFF);
		enc(64'd1);
		enc(64'd127);
		enc(64'd128);
		enc(64'h8000_0000_0000_0000);
		enc(64'h7FFF_FFFF_FFFF_FFFF);
		dec(8'h80);
		dec(8'hFF);
		dec(8'h01);
		dec(8'h80);
		dec(8'h00);
		dec(8'h7F);
		enc(64'd5);
		dec(8'hFF);
		// eleven groups of ones push bits out of the accumulator
		repeat (10) dec(8'h7F);
		dec(8'hFF);

		while (words_sent < 260) begin
			if ($urandom_range(0, 9) == 0)
				send_burst = !send_burst;
			if ($urandom_range(0, 9) == 0)
				take_burst = !take_burst;
			if (!pressed && words_sent > 130) begin
				pressed = 1'b1;
				hold_pending = 1'b1;
				send_burst = 1'b1;
				repeat (12) enc({$urandom, $urandom});
				send_burst = 1'b0;
			end
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				enc(rand_value());
			end else if (pick < 75) begin
				send_number(rand_value(), $urandom_range(0, 4) == 0);
			end else if (pick < 85) begin
				repeat ($urandom_range(9, 13)) dec({1'b0, 7'($urandom)});
				dec({1'b1, 7'($urandom)});
			end else if (pick < 95) begin
				dec(8'($urandom));
			end else begin
				enc(64'd0);
			end
		end
		item_valid <= 1'b0;

		while (codec_track.results_due.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
		if (codec_track.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
